>>> sv/tscws_pkg.sv
package tscws_pkg;

  localparam int TIME_W  = 24;
  localparam int PAD_W   = 16;
  localparam int OP_W    = 2;
  localparam int ROWID_W = 2;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_LOAD,
    K_QUERY
  } kind_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [ROWID_W-1:0] row_id;
    logic [TIME_W-1:0]  cluster_time;
    logic [PAD_W-1:0]   cluster_pad;
    logic               close_row;
    logic [TIME_W-1:0]  time_low;
    logic [TIME_W-1:0]  time_high;
    logic [PAD_W-1:0]   pad_low;
    logic [PAD_W-1:0]   pad_high;
    logic               want_list;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
    logic [CNT_W-1:0] match_count;
    logic [POS_W-1:0] cluster_index;
    logic             index_valid;
    logic             overflow;
    logic             last;
  } out_item_t;

  typedef struct packed {
    kind_t    kind;
    logic     row_ok;
    in_item_t item;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_WT,
    ST_SCAN_RD,
    ST_SCAN_WT,
    ST_SORT_WR,
    ST_BS,
    ST_BS_SO,
    ST_BS_T,
    ST_W_RD,
    ST_W_SO,
    ST_W_T,
    ST_SUM,
    ST_L_RD,
    ST_L_SO,
    ST_L_PAD
  } state_t;

endpackage

>>> sv/tscws_ram.sv
module tscws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/tscws_front.sv
module tscws_front #(
  parameter int ROWS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  tscws_pkg::in_item_t in_item,
  output logic               cmd_valid,
  output tscws_pkg::cmd_t    cmd,
  input  logic               cmd_take
);
  import tscws_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       row_ok, keep, acc, take;
  cmd_t       c;

  always_comb begin
    row_ok = 32'(in_item.row_id) < ROWS;
    c.item = in_item;
    c.row_ok = row_ok;
    c.kind = K_QUERY;
    keep = 1'b0;
    unique case (in_item.operation)
      OP_CLEAR: begin
        c.kind = K_CLEAR;
        keep = row_ok;
      end
      OP_LOAD: begin
        c.kind = K_LOAD;
        keep = row_ok;
      end
      OP_QUERY: begin
        c.kind = K_QUERY;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full      = cnt_r == 2'd2;
  assign acc       = push && !full && keep;
  assign cmd_valid = cnt_r != 2'd0;
  assign take      = cmd_take && cmd_valid;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r] <= c;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc) begin
        wp_r <= !wp_r;
      end
      if (take) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(acc) - 2'(take);
    end
  end
endmodule

>>> sv/tscws_back.sv
module tscws_back #(
  parameter int ROWS     = 4,
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  tscws_pkg::cmd_t      cmd,
  output logic                 cmd_take,
  input  logic                 pop,
  output logic                 empty,
  output tscws_pkg::out_item_t out_item
);
  import tscws_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = PW + 1;
  localparam int AW = RW + PW;

  state_t st_r, st_nxt;
  logic [RW-1:0] row_r, row_nxt, ridx;
  logic [CW-1:0] n_r, n_nxt, left_r, left_nxt, right_r, right_nxt, mid_r, mid_nxt;
  logic [CW-1:0] p_r, p_nxt, cnt_r, cnt_nxt, emit_r, emit_nxt, cnt_inc, nfill;
  logic [PW-1:0] i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt, li_r, li_nxt;
  logic [PW-1:0] first_r, first_nxt, last_r, last_nxt;
  logic [TIME_W-1:0] key_r, key_nxt, tlo_r, tlo_nxt, thi_r, thi_nxt;
  logic [PAD_W-1:0] plo_r, plo_nxt, phi_r, phi_nxt;
  logic want_r, want_nxt, ovq_r, ovq_nxt, found_r, found_nxt;

  logic [CW-1:0] fill_r [ROWS];
  logic [CW-1:0] fill_nxt [ROWS];
  logic [ROWS-1:0] closed_r, closed_nxt, ovf_r, ovf_nxt;

  logic tp_we, so_we;
  logic [AW-1:0] tp_waddr, tp_raddr, so_waddr, so_raddr;
  logic [TIME_W-1:0] t_rdata;
  logic [PAD_W-1:0] p_rdata;
  logic [PW-1:0] so_wdata, so_rdata;

  logic out_v_r, out_ld, can_ld, pad_ok;
  out_item_t out_r, out_nxt;

  tscws_ram #(.WIDTH(TIME_W), .DEPTH(2**AW)) u_time (
    .clk, .we(tp_we), .waddr(tp_waddr), .wdata(cmd.item.cluster_time),
    .raddr(tp_raddr), .rdata(t_rdata));
  tscws_ram #(.WIDTH(PAD_W), .DEPTH(2**AW)) u_pad (
    .clk, .we(tp_we), .waddr(tp_waddr), .wdata(cmd.item.cluster_pad),
    .raddr(tp_raddr), .rdata(p_rdata));
  tscws_ram #(.WIDTH(PW), .DEPTH(2**AW)) u_order (
    .clk, .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
    .raddr(so_raddr), .rdata(so_rdata));

  assign empty    = !out_v_r;
  assign out_item = out_r;
  assign can_ld   = !out_v_r || pop;
  assign ridx     = RW'(cmd.item.row_id);
  assign pad_ok   = (p_rdata >= plo_r) && (p_rdata <= phi_r);

  always_comb begin
    st_nxt = st_r;   row_nxt = row_r;   n_nxt = n_r;
    left_nxt = left_r; right_nxt = right_r; mid_nxt = mid_r;
    p_nxt = p_r; cnt_nxt = cnt_r; emit_nxt = emit_r;
    i_nxt = i_r; j_nxt = j_r; rank_nxt = rank_r; li_nxt = li_r;
    first_nxt = first_r; last_nxt = last_r; key_nxt = key_r;
    tlo_nxt = tlo_r; thi_nxt = thi_r; plo_nxt = plo_r; phi_nxt = phi_r;
    want_nxt = want_r; ovq_nxt = ovq_r; found_nxt = found_r;
    fill_nxt = fill_r; closed_nxt = closed_r; ovf_nxt = ovf_r;
    cmd_take = 1'b0;
    tp_we = 1'b0; tp_waddr = '0; tp_raddr = '0;
    so_we = 1'b0; so_waddr = '0; so_raddr = '0; so_wdata = i_r;
    out_ld = 1'b0;
    cnt_inc = cnt_r;
    nfill = '0;
    out_nxt.found         = found_r;
    out_nxt.first_pos     = found_r ? POS_W'(first_r) : '0;
    out_nxt.last_pos      = found_r ? POS_W'(last_r) : '0;
    out_nxt.match_count   = CNT_W'(cnt_r);
    out_nxt.cluster_index = '0;
    out_nxt.index_valid   = 1'b0;
    out_nxt.overflow      = ovq_r;
    out_nxt.last          = 1'b1;

    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          unique case (cmd.kind)
            K_CLEAR: begin
              fill_nxt[ridx]   = '0;
              closed_nxt[ridx] = 1'b0;
              ovf_nxt[ridx]    = 1'b0;
            end
            K_LOAD: begin
              if (!closed_r[ridx]) begin
                nfill = fill_r[ridx];
                if (fill_r[ridx] < CW'(CAPACITY)) begin
                  tp_we = 1'b1;
                  tp_waddr = {ridx, fill_r[ridx][PW-1:0]};
                  nfill = fill_r[ridx] + 1'b1;
                  fill_nxt[ridx] = nfill;
                end else begin
                  ovf_nxt[ridx] = 1'b1;
                end
                if (cmd.item.close_row) begin
                  closed_nxt[ridx] = 1'b1;
                  row_nxt = ridx;
                  n_nxt = nfill;
                  i_nxt = '0;
                  st_nxt = (nfill == '0) ? ST_IDLE : ST_KEY_RD;
                end
              end
            end
            K_QUERY: begin
              row_nxt  = ridx;
              tlo_nxt  = cmd.item.time_low;
              thi_nxt  = cmd.item.time_high;
              plo_nxt  = cmd.item.pad_low;
              phi_nxt  = cmd.item.pad_high;
              want_nxt = cmd.item.want_list;
              ovq_nxt  = cmd.row_ok ? ovf_r[ridx] : 1'b0;
              n_nxt    = (cmd.row_ok && closed_r[ridx]) ? fill_r[ridx] : '0;
              left_nxt = '0;
              right_nxt = n_nxt;
              st_nxt   = ST_BS;
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      // stable rank sort: rank = earlier-or-smaller count
      ST_KEY_RD: begin
        tp_raddr = {row_r, i_r};
        st_nxt = ST_KEY_WT;
      end
      ST_KEY_WT: begin
        key_nxt = t_rdata;
        j_nxt = '0;
        rank_nxt = '0;
        st_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        tp_raddr = {row_r, j_r};
        st_nxt = ST_SCAN_WT;
      end
      ST_SCAN_WT: begin
        if (t_rdata < key_r || (t_rdata == key_r && j_r < i_r)) begin
          rank_nxt = rank_r + 1'b1;
        end
        if ({1'b0, j_r} == n_r - 1'b1) begin
          st_nxt = ST_SORT_WR;
        end else begin
          j_nxt = j_r + 1'b1;
          st_nxt = ST_SCAN_RD;
        end
      end
      ST_SORT_WR: begin
        so_we = 1'b1;
        so_waddr = {row_r, rank_r};
        so_wdata = i_r;
        if ({1'b0, i_r} == n_r - 1'b1) begin
          st_nxt = ST_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
          st_nxt = ST_KEY_RD;
        end
      end
      // lower-bound search on time_low
      ST_BS: begin
        if (left_r < right_r) begin
          mid_nxt = left_r + ((right_r - left_r) >> 1);
          so_raddr = {row_r, mid_nxt[PW-1:0]};
          st_nxt = ST_BS_SO;
        end else begin
          first_nxt = left_r[PW-1:0];
          last_nxt = '0;
          p_nxt = left_r;
          cnt_nxt = '0;
          found_nxt = 1'b0;
          st_nxt = (left_r < n_r) ? ST_W_RD : ST_SUM;
        end
      end
      ST_BS_SO: begin
        tp_raddr = {row_r, so_rdata};
        st_nxt = ST_BS_T;
      end
      ST_BS_T: begin
        if (t_rdata < tlo_r) begin
          left_nxt = mid_r + 1'b1;
        end else begin
          right_nxt = mid_r;
        end
        st_nxt = ST_BS;
      end
      ST_W_RD: begin
        so_raddr = {row_r, p_r[PW-1:0]};
        st_nxt = ST_W_SO;
      end
      ST_W_SO: begin
        tp_raddr = {row_r, so_rdata};
        li_nxt = so_rdata;
        st_nxt = ST_W_T;
      end
      ST_W_T: begin
        if (t_rdata > thi_r) begin
          st_nxt = (want_r && cnt_r != '0) ? ST_L_RD : ST_SUM;
          p_nxt = CW'(first_r);
          emit_nxt = '0;
        end else begin
          found_nxt = 1'b1;
          last_nxt = p_r[PW-1:0];
          if (pad_ok) begin
            cnt_inc = cnt_r + 1'b1;
          end
          cnt_nxt = cnt_inc;
          if (p_r + 1'b1 == n_r) begin
            st_nxt = (want_r && cnt_inc != '0) ? ST_L_RD : ST_SUM;
            p_nxt = CW'(first_r);
            emit_nxt = '0;
          end else begin
            p_nxt = p_r + 1'b1;
            st_nxt = ST_W_RD;
          end
        end
      end
      ST_SUM: begin
        if (can_ld) begin
          out_ld = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      // second pass over the window lists the hits
      ST_L_RD: begin
        so_raddr = {row_r, p_r[PW-1:0]};
        st_nxt = ST_L_SO;
      end
      ST_L_SO: begin
        tp_raddr = {row_r, so_rdata};
        li_nxt = so_rdata;
        st_nxt = ST_L_PAD;
      end
      ST_L_PAD: begin
        // keep the pad read alive while the output stalls
        tp_raddr = {row_r, li_r};
        if (!pad_ok) begin
          p_nxt = p_r + 1'b1;
          st_nxt = ST_L_RD;
        end else if (can_ld) begin
          out_ld = 1'b1;
          out_nxt.cluster_index = POS_W'(li_r);
          out_nxt.index_valid = 1'b1;
          out_nxt.last = (emit_r + 1'b1 == cnt_r);
          emit_nxt = emit_r + 1'b1;
          p_nxt = p_r + 1'b1;
          st_nxt = (emit_r + 1'b1 == cnt_r) ? ST_IDLE : ST_L_RD;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;   n_r <= n_nxt;
    left_r <= left_nxt; right_r <= right_nxt; mid_r <= mid_nxt;
    p_r <= p_nxt; cnt_r <= cnt_nxt; emit_r <= emit_nxt;
    i_r <= i_nxt; j_r <= j_nxt; rank_r <= rank_nxt; li_r <= li_nxt;
    first_r <= first_nxt; last_r <= last_nxt; key_r <= key_nxt;
    tlo_r <= tlo_nxt; thi_r <= thi_nxt; plo_r <= plo_nxt; phi_r <= phi_nxt;
    want_r <= want_nxt; ovq_r <= ovq_nxt; found_r <= found_nxt;
    if (out_ld) begin
      out_r <= out_nxt;
    end
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      out_v_r  <= 1'b0;
      closed_r <= '0;
      ovf_r    <= '0;
      for (int k = 0; k < ROWS; k++) begin
        fill_r[k] <= '0;
      end
    end else begin
      st_r     <= st_nxt;
      closed_r <= closed_nxt;
      ovf_r    <= ovf_nxt;
      fill_r   <= fill_nxt;
      if (out_ld) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end
endmodule

>>> sv/time_sorted_cluster_window_search.sv
// Clear and load: each is done in the back end's idle state after the command queue.
// A closing load then sorts the row's n clusters by rank.
// Query: a lower-bound search on time_low, then a walk over the window of w clusters,
// then, if a list is wanted, a second walk that lists the hits; the listing waits on pop.
// Reset (rst_n low, synchronous) empties both queues and marks every row open and empty.
module time_sorted_cluster_window_search #(
  parameter int ROWS     = 4,
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  tscws_pkg::in_item_t  in_item,
  output logic                 empty,
  input  logic                 pop,
  output tscws_pkg::out_item_t out_item
);
  import tscws_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;

  tscws_front #(.ROWS(ROWS)) u_front (
    .clk, .rst_n, .push, .full, .in_item, .cmd_valid, .cmd, .cmd_take);

  tscws_back #(.ROWS(ROWS), .CAPACITY(CAPACITY)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .pop, .empty, .out_item);

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");
  a_hit_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.index_valid) |-> (out_item.found && out_item.match_count != '0))
    else $error("listed hit without match");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.found) |->
    (out_item.match_count == '0 && out_item.first_pos == '0 && out_item.last_pos == '0))
    else $error("summary fields set without a find");
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.found) |-> (out_item.first_pos <= out_item.last_pos))
    else $error("window span reversed");
`endif
endmodule
